// ===== rtl/core/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// PCR pacing package
// Shared widths, constants, register indexes and beat types of the PCR-paced
// packet release block.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int unsigned PidW   = 13;
  localparam int unsigned RefW   = 42;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned WaitW  = 32;
  localparam int unsigned BurstW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PidW-1:0]   NullPid          = 13'd8191;
  localparam logic [RefW-1:0]   RefModulus       = 42'd2576980377600;
  localparam logic [RefW-1:0]   MaxGapTicks      = 42'd54000000;
  localparam logic [WaitW-1:0]  DefaultWaitTicks = 32'd1350000;

  localparam logic [PidW-1:0]   ResetRefPid      = NullPid;
  localparam logic [WaitW-1:0]  ResetMinWait     = 32'd1350000;
  localparam logic [BurstW-1:0] ResetBurst       = 16'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_PID  = 2'd0,
    CFG_MIN_WAIT = 2'd1,
    CFG_BURST    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PidW-1:0]  packet_pid;
    logic             has_clock_ref;
    logic [RefW-1:0]  clock_ref;
    logic [TimeW-1:0] now_ticks;
  } in_beat_t;

  typedef struct packed {
    logic             flush;
    logic             hold;
    logic [TimeW-1:0] release_time;
  } out_beat_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== rtl/core/pcr_stream_if.sv =====
// ----------------------------------------------------------------------------
// PCR pacing stream interfaces
// Valid/ready channels for packet beats in and pacing results out.
// ----------------------------------------------------------------------------
interface pcr_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcr_pkg::PidW-1:0]  packet_pid;
  logic                      has_clock_ref;
  logic [pcr_pkg::RefW-1:0]  clock_ref;
  logic [pcr_pkg::TimeW-1:0] now_ticks;

  modport source (output valid, packet_pid, has_clock_ref, clock_ref, now_ticks,
                  input ready);
  modport sink   (input valid, packet_pid, has_clock_ref, clock_ref, now_ticks,
                  output ready);
endinterface

interface pcr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      flush;
  logic                      hold;
  logic [pcr_pkg::TimeW-1:0] release_time;

  modport source (output valid, flush, hold, release_time, input ready);
  modport sink   (input valid, flush, hold, release_time, output ready);
endinterface

// ===== rtl/core/pcr_paced_packet_release.sv =====
// ----------------------------------------------------------------------------
// PCR-paced packet release
// Locks to a reference PID, follows its PCRs onto local time and tells when
// a packet must be held until a release time and when a burst is flushed.
//
//   Port         Dir   Beat
//   in_i         sink  packet_pid, has_clock_ref, clock_ref, now_ticks
//   out_o        src   flush, hold, release_time
//   cfg_*_i      in    register index and write data, no handshake
//
// A packet beat enters the input register; its result moves into the output
// register when that is free. One beat is taken every cycle unless the output
// stalls. Reset loads the register defaults and clears all regulation state.
// A stalled output holds its result and the input register in turn.
// ----------------------------------------------------------------------------
module pcr_paced_packet_release (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pcr_in_if.sink                          in_i,
  pcr_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [pcr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pcr_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic               s1_valid;
  pcr_pkg::in_beat_t  s1_beat;
  logic               out_free;
  logic               step;
  pcr_pkg::out_beat_t result;
  pcr_pkg::cfg_wr_t   cfg;

  assign step      = s1_valid && out_free;
  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  pcr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (step),
    .valid_o (s1_valid),
    .beat_o  (s1_beat)
  );

  pcr_pace_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .beat_i   (s1_beat),
    .result_o (result)
  );

  pcr_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  a_hold_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.hold |-> out_o.flush)
    else $error("hold without flush");

  a_time_only_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hold |-> out_o.release_time == '0)
    else $error("release time set without hold");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while both stages are full");

endmodule

// ===== rtl/core/pcr_in_stage.sv =====
// ----------------------------------------------------------------------------
// PCR pacing input stage
// Registers one accepted packet beat until the pacing core consumes it.
// ----------------------------------------------------------------------------
module pcr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcr_in_if.sink            in_i,
  input  logic              take_i,
  output logic              valid_o,
  output pcr_pkg::in_beat_t beat_o
);

  logic              valid_q, valid_d;
  pcr_pkg::in_beat_t beat_q, beat_d;
  logic              load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load) begin
      valid_d              = 1'b1;
      beat_d.packet_pid    = in_i.packet_pid;
      beat_d.has_clock_ref = in_i.has_clock_ref;
      beat_d.clock_ref     = in_i.clock_ref;
      beat_d.now_ticks     = in_i.now_ticks;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/pcr_pace_core.sv =====
// ----------------------------------------------------------------------------
// PCR pacing core
// Holds the configuration and the regulation state, and computes one result
// per packet in a single pass.
// ----------------------------------------------------------------------------
module pcr_pace_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcr_pkg::cfg_wr_t   cfg_i,
  input  logic               step_i,
  input  pcr_pkg::in_beat_t  beat_i,
  output pcr_pkg::out_beat_t result_o
);

  localparam int unsigned SeqW = pcr_pkg::RefW + 2;

  logic [pcr_pkg::WaitW-1:0]  min_wait_q;
  logic [pcr_pkg::BurstW-1:0] burst_q;

  logic [pcr_pkg::PidW-1:0]   active_pid_q, active_pid_d;
  logic                       started_q, started_d;
  logic [pcr_pkg::RefW-1:0]   last_ref_q, last_ref_d;
  logic                       last_ref_valid_q, last_ref_valid_d;
  // The base is first_time + wrap_offset - first_ref, modulo 2^64.
  logic [pcr_pkg::TimeW-1:0]  base_q, base_d;
  logic [pcr_pkg::TimeW-1:0]  last_release_q, last_release_d;
  logic [pcr_pkg::BurstW-1:0] burst_count_q, burst_count_d;

  logic [pcr_pkg::PidW-1:0]   eff_pid;
  logic                       match;
  logic                       below, above, in_seq, restart, wrap;
  logic [SeqW-1:0]            pcr_ext, last_ext, gap_lim;
  logic [pcr_pkg::TimeW-1:0]  wrap_add, due, step;
  logic [pcr_pkg::WaitW-1:0]  wait_ticks;
  logic                       hold;
  logic [pcr_pkg::BurstW:0]   count_inc;
  logic                       flush;

  always_comb begin
    eff_pid = (beat_i.has_clock_ref && (active_pid_q == pcr_pkg::NullPid))
              ? beat_i.packet_pid : active_pid_q;
    match   = beat_i.has_clock_ref && (beat_i.packet_pid == eff_pid);

    pcr_ext  = SeqW'(beat_i.clock_ref);
    last_ext = SeqW'(last_ref_q);
    gap_lim  = last_ext + SeqW'(pcr_pkg::MaxGapTicks);
    below    = beat_i.clock_ref < last_ref_q;
    above    = beat_i.clock_ref > last_ref_q;
    if (!last_ref_valid_q) begin
      in_seq = 1'b1;
    end else if (below) begin
      in_seq = (pcr_ext + SeqW'(pcr_pkg::RefModulus)) < gap_lim;
    end else if (above) begin
      in_seq = pcr_ext < gap_lim;
    end else begin
      in_seq = 1'b0;
    end
    restart = !started_q || !in_seq;
    wrap    = last_ref_valid_q && below;

    wrap_add   = wrap ? pcr_pkg::TimeW'(pcr_pkg::RefModulus) : '0;
    due        = base_q + wrap_add + pcr_pkg::TimeW'(beat_i.clock_ref);
    step       = due - last_release_q;
    wait_ticks = (min_wait_q != '0) ? min_wait_q : pcr_pkg::DefaultWaitTicks;
    hold       = match && !restart && !step[pcr_pkg::TimeW-1]
                 && (step >= pcr_pkg::TimeW'(wait_ticks));

    count_inc = {1'b0, burst_count_q} + 1'b1;
    flush     = hold || (count_inc >= {1'b0, burst_q});

    result_o.flush        = flush;
    result_o.hold         = hold;
    result_o.release_time = hold ? due : '0;
  end

  always_comb begin
    active_pid_d     = active_pid_q;
    started_d        = started_q;
    last_ref_d       = last_ref_q;
    last_ref_valid_d = last_ref_valid_q;
    base_d           = base_q;
    last_release_d   = last_release_q;
    burst_count_d    = burst_count_q;

    if (step_i) begin
      active_pid_d  = eff_pid;
      burst_count_d = flush ? '0 : count_inc[pcr_pkg::BurstW-1:0];
      if (match) begin
        started_d        = 1'b1;
        last_ref_d       = beat_i.clock_ref;
        last_ref_valid_d = 1'b1;
        if (restart) begin
          base_d         = beat_i.now_ticks - pcr_pkg::TimeW'(beat_i.clock_ref);
          last_release_d = beat_i.now_ticks;
        end else begin
          base_d = base_q + wrap_add;
          if (hold) begin
            last_release_d = due;
          end
        end
      end
    end

    if (cfg_i.we && (cfg_i.idx == pcr_pkg::CFG_REF_PID)
        && (cfg_i.wdata[pcr_pkg::PidW-1:0] != active_pid_q)) begin
      burst_count_d = '0;
      started_d     = 1'b0;
      active_pid_d  = cfg_i.wdata[pcr_pkg::PidW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_wait_q <= pcr_pkg::ResetMinWait;
      burst_q    <= pcr_pkg::ResetBurst;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        pcr_pkg::CFG_MIN_WAIT: min_wait_q <= cfg_i.wdata[pcr_pkg::WaitW-1:0];
        pcr_pkg::CFG_BURST:    burst_q    <= cfg_i.wdata[pcr_pkg::BurstW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_pid_q     <= pcr_pkg::ResetRefPid;
      started_q        <= 1'b0;
      last_ref_q       <= '0;
      last_ref_valid_q <= 1'b0;
      base_q           <= '0;
      last_release_q   <= '0;
      burst_count_q    <= '0;
    end else begin
      active_pid_q     <= active_pid_d;
      started_q        <= started_d;
      last_ref_q       <= last_ref_d;
      last_ref_valid_q <= last_ref_valid_d;
      base_q           <= base_d;
      last_release_q   <= last_release_d;
      burst_count_q    <= burst_count_d;
    end
  end

endmodule

// ===== rtl/core/pcr_out_stage.sv =====
// ----------------------------------------------------------------------------
// PCR pacing output stage
// Result register that holds a finished beat until the sink takes it.
// ----------------------------------------------------------------------------
module pcr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pcr_pkg::out_beat_t result_i,
  output logic               free_o,
  pcr_out_if.source          out_o
);

  logic               valid_q, valid_d;
  pcr_pkg::out_beat_t result_q, result_d;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (load_i) begin
      valid_d  = 1'b1;
      result_d = result_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_o.valid        = valid_q;
  assign out_o.flush        = result_q.flush;
  assign out_o.hold         = result_q.hold;
  assign out_o.release_time = result_q.release_time;

endmodule
